// ===== hw/rtl/spq_pkg.sv =====
package spq_pkg;

	// request kinds carried on s_tuser
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_FIND   = 2'd2;

	// fixed field widths on the ports
	localparam int REQ_W   = 2;
	localparam int FIELD_W = 32;
	localparam int POS_W   = 4;
	localparam int CNT_W   = 5;

	// result word layout, lowest bit up
	localparam int OUT_SUCCESS_LSB  = 0;
	localparam int OUT_POS_LSB      = OUT_SUCCESS_LSB + 1;
	localparam int OUT_OVF_LSB      = OUT_POS_LSB + POS_W;
	localparam int OUT_HEAD_LSB     = OUT_OVF_LSB + 1;
	localparam int OUT_HVALID_LSB   = OUT_HEAD_LSB + FIELD_W;
	localparam int OUT_CNT_LSB      = OUT_HVALID_LSB + 1;
	localparam int OUT_USED_W       = OUT_CNT_LSB + CNT_W;
	localparam int OUT_W            = ((OUT_USED_W + 7) / 8) * 8;

	// operation broadcast down the chain
	typedef struct packed {
		logic ins;
		logic rem;
	} spq_op_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
module spq_cell
	import spq_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spq_op_t                       op,
	input  logic signed [VALUE_WIDTH-1:0] key,
	input  logic signed [VALUE_WIDTH-1:0] prev_val,
	input  logic                          prev_occ,
	input  logic                          prev_fill,
	input  logic signed [VALUE_WIDTH-1:0] next_val,
	input  logic                          next_occ,
	output logic signed [VALUE_WIDTH-1:0] val,
	output logic signed [VALUE_WIDTH-1:0] val_d,
	output logic                          occ,
	output logic                          ge,
	output logic                          eq,
	output logic                          fill
);

	logic signed [VALUE_WIDTH-1:0] val_q;
	logic                          occ_q;
	logic                          occ_d;

	// key at or above the held value: insert point or shift region
	assign ge   = occ_q & (key >= val_q);
	assign eq   = occ_q & (key == val_q);
	assign fill = ge | ~occ_q;

	always_comb begin
		val_d = val_q;
		occ_d = occ_q;
		if (op.ins) begin
			if (fill) begin
				val_d = prev_fill ? prev_val : key;
			end
			occ_d = occ_q | prev_occ;
		end else if (op.rem) begin
			if (ge) begin
				val_d = next_val;
			end
			occ_d = next_occ;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			occ_q <= occ_d;
		end
	end

	assign val = val_q;
	assign occ = occ_q;

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// sorted priority queue: up to CAPACITY signed values kept largest first
//
// input channel s_*: one word per request. s_tuser holds the request kind
// (insert, remove first match, find first match); s_tdata holds the value.
// output channel m_*: exactly one result word per request, in order, giving
// success, match position, overflow, then head value, head-valid flag and
// element count as they stand after the request.
//
// the store is a row of CAPACITY identical cells. each cell compares the
// broadcast value with its own entry, and in the same cycle takes its
// neighbour's entry (shift towards the tail on insert, towards the head on
// remove), so a request finishes in the cycle it is accepted.
// the result word is valid in the cycle after the request is taken.
// throughput: one request per cycle unless the receiver stalls, set by the
// single compare-and-shift pass through the cell row and position encoder.
//
// reset empties the queue and drops any pending result word. the result
// sits in an output register; while the receiver stalls, a new request is
// still taken in the cycle the waiting word is taken, otherwise s_tready
// stays low and the queue holds.
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [FIELD_W-1:0] s_tdata,   // item_value
	input  logic [REQ_W-1:0]   s_tuser,   // req_type
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata    // success, match_position, overflow,
	                                      // head_value, head_valid, element_count
);

	localparam int PIW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CIW = $clog2(CAPACITY + 1);

	logic                          accept;
	logic signed [VALUE_WIDTH-1:0] key;
	spq_op_t                       op;

	// chain taps, one per cell
	logic signed [VALUE_WIDTH-1:0] cell_val   [CAPACITY];
	logic signed [VALUE_WIDTH-1:0] cell_val_d [CAPACITY];
	logic [CAPACITY-1:0]           cell_occ;
	logic [CAPACITY-1:0]           cell_ge;
	logic [CAPACITY-1:0]           cell_eq;
	logic [CAPACITY-1:0]           cell_fill;
	logic [CAPACITY-1:0]           first_ge;

	logic [CIW-1:0]     count_q;
	logic [CIW-1:0]     count_d;
	logic               full;
	logic               found;
	logic [PIW-1:0]     pos;
	logic               is_ins;
	logic               is_rem;
	logic               is_find;
	logic               success;
	logic               overflow;
	logic [FIELD_W-1:0] head_field;

	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;

	assign s_tready = ~m_tvalid_q | m_tready;
	assign accept   = s_tvalid & s_tready;

	// bring the value to the internal width: sign extended when wider, truncated when narrower
	if (VALUE_WIDTH >= FIELD_W) begin : g_key_wide
		assign key        = VALUE_WIDTH'(signed'(s_tdata));
		assign head_field = (count_d != '0) ? cell_val_d[0][FIELD_W-1:0] : '0;
	end else begin : g_key_narrow
		assign key        = s_tdata[VALUE_WIDTH-1:0];
		assign head_field = (count_d != '0) ? FIELD_W'(cell_val_d[0]) : '0;
	end

	assign is_ins  = accept & (s_tuser == REQ_INSERT);
	assign is_rem  = accept & (s_tuser == REQ_REMOVE);
	assign is_find = accept & (s_tuser == REQ_FIND);

	assign full  = cell_occ[CAPACITY-1];
	assign found = |cell_eq;

	assign op.ins = is_ins & ~full;
	assign op.rem = is_rem & found;

	// the row of cells; the head end sees an occupied, non-filling neighbour
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VALUE_WIDTH-1:0] prev_val;
		logic                          prev_occ;
		logic                          prev_fill;
		logic signed [VALUE_WIDTH-1:0] next_val;
		logic                          next_occ;

		if (i == 0) begin : g_head
			assign prev_val  = key;
			assign prev_occ  = 1'b1;
			assign prev_fill = 1'b0;
		end else begin : g_mid
			assign prev_val  = cell_val[i-1];
			assign prev_occ  = cell_occ[i-1];
			assign prev_fill = cell_fill[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_val = key;
			assign next_occ = 1'b0;
		end else begin : g_inner
			assign next_val = cell_val[i+1];
			assign next_occ = cell_occ[i+1];
		end

		spq_cell #(
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (op),
			.key      (key),
			.prev_val (prev_val),
			.prev_occ (prev_occ),
			.prev_fill(prev_fill),
			.next_val (next_val),
			.next_occ (next_occ),
			.val      (cell_val[i]),
			.val_d    (cell_val_d[i]),
			.occ      (cell_occ[i]),
			.ge       (cell_ge[i]),
			.eq       (cell_eq[i]),
			.fill     (cell_fill[i])
		);

		// entries are sorted, so the ge flags form one run up to the last occupied cell
		if (i == 0) begin : g_edge0
			assign first_ge[i] = cell_ge[i];
		end else begin : g_edge
			assign first_ge[i] = cell_ge[i] & ~cell_ge[i-1];
		end
	end

	// position of the first match: the start of the ge run
	always_comb begin
		pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first_ge[i]) begin
				pos = pos | PIW'(i);
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (op.ins) begin
			count_d = count_q + CIW'(1);
		end else if (op.rem) begin
			count_d = count_q - CIW'(1);
		end
	end

	assign success  = op.ins | ((is_rem | is_find) & found);
	assign overflow = is_ins & full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result word, packed from the lowest bit up
	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= OUT_W'({
				CNT_W'(count_d),
				(count_d != '0),
				head_field,
				overflow,
				((is_rem | is_find) & found) ? POS_W'(pos) : POS_W'(0),
				success
			});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== hw/rtl/spq_checker.sv =====
module spq_checker
	import spq_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [OUT_W-1:0]   m_tdata
);

	logic [CNT_W-1:0]   cnt;
	logic [FIELD_W-1:0] head;
	logic               hvalid;
	logic               succ;
	logic               ovf;

	assign cnt    = m_tdata[OUT_CNT_LSB +: CNT_W];
	assign head   = m_tdata[OUT_HEAD_LSB +: FIELD_W];
	assign hvalid = m_tdata[OUT_HVALID_LSB];
	assign succ   = m_tdata[OUT_SUCCESS_LSB];
	assign ovf    = m_tdata[OUT_OVF_LSB];

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed under stall");

	// a result word is valid in the cycle after each accepted request
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("no result after accepted request");

	// head flag agrees with the count, empty queue shows a zero head
	a_head: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (hvalid == (cnt != '0)) && (hvalid || head == '0))
		else $error("head fields disagree with count");

	// a rejected insert is never a success
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ovf |-> !succ)
		else $error("overflow reported with success");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import spq_pkg::*;

	localparam int QCAP = 16;
	// request code that the block leaves unused: it still gets a status word
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	// cycles with no word moving on either side before the run is called dead
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_OFF_CYCLES = 240;
	localparam int PHASE_COUNT = 8;
	localparam int PHASE_ITEMS = 100;

	// status word as it sits in m_tdata, lowest field last in the struct
	typedef struct packed {
		logic [CNT_W-1:0]   count;
		logic               head_valid;
		logic [FIELD_W-1:0] head;
		logic               overflow;
		logic [POS_W-1:0]   position;
		logic               success;
	} status_word_t;

	// sorted list mirror: predicts one status word per request taken
	class sorted_queue_model;
		logic signed [FIELD_W-1:0] model_slots [QCAP];
		int                        model_fill = 0;
		status_word_t              awaited_status [$];
		int                        errors = 0;

		function int pending();
			return awaited_status.size();
		endfunction

		function void note_request(logic [REQ_W-1:0] req, logic signed [FIELD_W-1:0] v);
			status_word_t st;
			int           i;
			int           j;
			st = '0;
			i = 0;
			case (req)
				REQ_INSERT: begin
					if (model_fill >= QCAP) begin
						st.overflow = 1'b1;
					end else begin
						// new value goes ahead of the first entry not above it
						while (i < model_fill && v < model_slots[i])
							i++;
						for (j = model_fill; j > i; j--)
							model_slots[j] = model_slots[j-1];
						model_slots[i] = v;
						model_fill++;
						st.success = 1'b1;
					end
				end
				REQ_REMOVE, REQ_FIND: begin
					while (i < model_fill && model_slots[i] != v)
						i++;
					if (i < model_fill) begin
						st.success  = 1'b1;
						st.position = i[POS_W-1:0];
						if (req == REQ_REMOVE) begin
							for (j = i; j + 1 < model_fill; j++)
								model_slots[j] = model_slots[j+1];
							model_fill--;
						end
					end
				end
				default: ;
			endcase
			st.head       = (model_fill > 0) ? model_slots[0] : '0;
			st.head_valid = (model_fill > 0);
			st.count      = model_fill[CNT_W-1:0];
			awaited_status.push_back(st);
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_W-1:0] word);
			status_word_t got;
			status_word_t want;
			got = word[OUT_USED_W-1:0];
			if (awaited_status.size() == 0) begin
				$error("status word 0x%h with no request waiting", word);
				errors++;
				return;
			end
			want = awaited_status.pop_front();
			compare_field("success", want.success, got.success);
			compare_field("match_position", want.position, got.position);
			compare_field("overflow", want.overflow, got.overflow);
			compare_field("head_value", $signed(want.head), $signed(got.head));
			compare_field("head_valid", want.head_valid, got.head_valid);
			compare_field("element_count", want.count, got.count);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [FIELD_W-1:0] s_tdata = '0;
	logic [REQ_W-1:0]   s_tuser = REQ_INSERT;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_W-1:0]   m_tdata;

	sorted_queue_model mirror = new();

	// idling knobs in percent of cycles, insert share in percent of requests
	int gap_pct = 0;
	int stall_pct = 0;
	int insert_pct = 50;
	int hold_request = 0;
	int quiet_cycles = 0;
	logic [FIELD_W-1:0] value_pool [8];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sorted_priority_queue u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // item_value
		.s_tuser  (s_tuser),   // req_type
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // success, match_position, overflow,
		                       // head_value, head_valid, element_count
	);

	// offer one request word, with random idle cycles ahead of it
	task automatic send_word(logic [REQ_W-1:0] req, logic [FIELD_W-1:0] val);
		while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= val;
		do @(posedge clk); while (!s_tready);
		mirror.note_request(req, val);
	endtask

	// sender goes quiet until every status word has come back
	task automatic drain_queue();
		s_tvalid <= 1'b0;
		while (mirror.pending() > 0)
			@(posedge clk);
	endtask

	// mostly values from a small pool so removes and finds hit stored entries
	function automatic void pick_request(output logic [REQ_W-1:0] req,
	                                     output logic [FIELD_W-1:0] val);
		int roll;
		roll = $urandom_range(99);
		if (roll < insert_pct)
			req = REQ_INSERT;
		else if (roll < insert_pct + (97 - insert_pct) * 2 / 3)
			req = REQ_REMOVE;
		else if (roll < 97)
			req = REQ_FIND;
		else
			req = REQ_UNUSED;
		if ($urandom_range(99) < 15)
			val = $urandom();
		else
			val = value_pool[$urandom_range(7)];
	endfunction

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				n = hold_request;
				hold_request = 0;
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			mirror.check_result(m_tdata);
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		logic [REQ_W-1:0]   req;
		logic [FIELD_W-1:0] val;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty queue misses, extremes, equal values, head and tail removal
		send_word(REQ_FIND, 32'd0);
		send_word(REQ_REMOVE, 32'd5);
		send_word(REQ_UNUSED, 32'hFFFF_FFFF);
		send_word(REQ_INSERT, 32'h7FFF_FFFF);
		send_word(REQ_INSERT, 32'h8000_0000);
		send_word(REQ_INSERT, 32'd0);
		send_word(REQ_INSERT, 32'd0);
		send_word(REQ_INSERT, 32'hFFFF_FFFF);
		send_word(REQ_FIND, 32'd0);
		send_word(REQ_FIND, 32'h8000_0000);
		send_word(REQ_UNUSED, 32'd0);
		send_word(REQ_FIND, 32'd12345);
		send_word(REQ_REMOVE, 32'h7FFF_FFFF);
		send_word(REQ_REMOVE, 32'h8000_0000);
		send_word(REQ_REMOVE, 32'd0);
		send_word(REQ_REMOVE, 32'hFFFF_FFFF);
		send_word(REQ_REMOVE, 32'd0);
		send_word(REQ_REMOVE, 32'd0);
		drain_queue();

		// random phases: fill-heavy and drain-heavy in turn, idling mode rotating
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 87; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 87; end
				default: begin gap_pct = 9; stall_pct = 9; end
			endcase
			insert_pct = (p % 2 == 0) ? 70 : 30;
			value_pool[0] = 32'h7FFF_FFFF;
			value_pool[1] = 32'h8000_0000;
			value_pool[2] = 32'd0;
			value_pool[3] = 32'hFFFF_FFFF;
			for (int k = 4; k < 7; k++)
				value_pool[k] = 32'($urandom_range(20)) - 32'd10;
			value_pool[7] = $urandom();
			// long receiver hold-off while the sender keeps offering
			if (p == 0)
				hold_request = HOLD_OFF_CYCLES;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick_request(req, val);
				send_word(req, val);
			end
			drain_queue();
		end

		repeat (8) @(posedge clk);
		if (mirror.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
